/* rtl/core/minv_pkg.sv */
// Shared types, constants and the microcode program of the modular inverse unit.
// Used by minv_seq and modular_inverse; depends on nothing else.
package minv_pkg;

	localparam int VW = 32;
	localparam int MW = 33;
	localparam int TW = 35;
	localparam int CW = 6;
	localparam int SW = 4;

	localparam logic [MW-1:0] MOD_MAX = {1'b1, {(MW-1){1'b0}}};

	typedef logic [SW-1:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_SETUP,
		OP_UPDATE,
		OP_RES_OK,
		OP_RES_FAIL,
		OP_OUTPUT
	} op_t;

	typedef enum logic [2:0] {
		CD_NONE,
		CD_ALWAYS,
		CD_CNT_NZ,
		CD_R1_ZERO,
		CD_M_SMALL,
		CD_GCD_NOT_ONE
	} cond_t;

	typedef enum logic [1:0] {
		WT_NONE,
		WT_IN,
		WT_OUT
	} wait_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		wait_t wt;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic cnt_nz;
		logic r1_zero;
		logic m_small;
		logic gcd_not_one;
	} stat_t;

	localparam step_t STEP_LOAD      = 4'd0;
	localparam step_t STEP_CHECK     = 4'd1;
	localparam step_t STEP_RED_START = 4'd2;
	localparam step_t STEP_RED_DIV   = 4'd3;
	localparam step_t STEP_SETUP     = 4'd4;
	localparam step_t STEP_TEST      = 4'd5;
	localparam step_t STEP_EU_START  = 4'd6;
	localparam step_t STEP_EU_DIV    = 4'd7;
	localparam step_t STEP_UPDATE    = 4'd8;
	localparam step_t STEP_GCD       = 4'd9;
	localparam step_t STEP_RES_OK    = 4'd10;
	localparam step_t STEP_RES_FAIL  = 4'd11;
	localparam step_t STEP_OUTPUT    = 4'd12;

	function automatic ctrl_t microcode(step_t s);
		ctrl_t c;
		c = '{op: OP_NOP, cond: CD_ALWAYS, wt: WT_NONE, target: STEP_LOAD};
		case (s)
			STEP_LOAD:      c = '{OP_LOAD,      CD_NONE,        WT_IN,   STEP_LOAD};
			STEP_CHECK:     c = '{OP_NOP,       CD_M_SMALL,     WT_NONE, STEP_RES_FAIL};
			STEP_RED_START: c = '{OP_DIV_START, CD_NONE,        WT_NONE, STEP_LOAD};
			STEP_RED_DIV:   c = '{OP_DIV_STEP,  CD_CNT_NZ,      WT_NONE, STEP_RED_DIV};
			STEP_SETUP:     c = '{OP_SETUP,     CD_NONE,        WT_NONE, STEP_LOAD};
			STEP_TEST:      c = '{OP_NOP,       CD_R1_ZERO,     WT_NONE, STEP_GCD};
			STEP_EU_START:  c = '{OP_DIV_START, CD_NONE,        WT_NONE, STEP_LOAD};
			STEP_EU_DIV:    c = '{OP_DIV_STEP,  CD_CNT_NZ,      WT_NONE, STEP_EU_DIV};
			STEP_UPDATE:    c = '{OP_UPDATE,    CD_ALWAYS,      WT_NONE, STEP_TEST};
			STEP_GCD:       c = '{OP_NOP,       CD_GCD_NOT_ONE, WT_NONE, STEP_RES_FAIL};
			STEP_RES_OK:    c = '{OP_RES_OK,    CD_ALWAYS,      WT_NONE, STEP_OUTPUT};
			STEP_RES_FAIL:  c = '{OP_RES_FAIL,  CD_NONE,        WT_NONE, STEP_LOAD};
			STEP_OUTPUT:    c = '{OP_OUTPUT,    CD_ALWAYS,      WT_OUT,  STEP_LOAD};
			default:        c = '{OP_NOP,       CD_ALWAYS,      WT_NONE, STEP_LOAD};
		endcase
		return c;
	endfunction

endpackage

/* rtl/core/minv_seq.sv */
// Microcode sequencer of the modular inverse unit: step counter, program table and jumps.
// Depends on minv_pkg for the control word, status and program.
module minv_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  minv_pkg::stat_t stat,
	output minv_pkg::ctrl_t ctrl
);
	import minv_pkg::*;

	step_t pc_q;
	step_t pc_d;
	logic  go;
	logic  take;

	assign ctrl = microcode(pc_q);

	always_comb begin
		case (ctrl.wt)
			WT_IN:   go = stat.in_valid;
			WT_OUT:  go = stat.out_free;
			default: go = 1'b1;
		endcase
		case (ctrl.cond)
			CD_ALWAYS:      take = 1'b1;
			CD_CNT_NZ:      take = stat.cnt_nz;
			CD_R1_ZERO:     take = stat.r1_zero;
			CD_M_SMALL:     take = stat.m_small;
			CD_GCD_NOT_ONE: take = stat.gcd_not_one;
			default:        take = 1'b0;
		endcase
		if (!go) begin
			pc_d = pc_q;
		end else if (take) begin
			pc_d = ctrl.target;
		end else begin
			pc_d = pc_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_LOAD;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

/* rtl/core/modular_inverse.sv */
// Modular inverse by the extended Euclidean algorithm: one item at a time, a new input
// beat is accepted only after the result of the previous item has been registered for
// output. Each quotient step runs in the shared shift-subtract divider.
// Reset clears the control state and sets the modulus to two to the thirty-second.
// Depends on minv_pkg and minv_seq.
module modular_inverse (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [minv_pkg::MW-1:0]    cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [minv_pkg::VW-1:0]    value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [minv_pkg::VW-1:0]    inverse_value,
	output logic                       not_invertible
);
	import minv_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	logic [MW-1:0]          modulus_q;
	logic [MW-1:0]          m_eff;
	logic [MW-1:0]          r0_q;
	logic [MW-1:0]          r1_q;
	logic [MW-1:0]          rem_q;
	logic signed [TW-1:0]   t0_q;
	logic signed [TW-1:0]   t1_q;
	logic signed [TW-1:0]   acc_q;
	logic [CW-1:0]          cnt_q;
	logic [VW-1:0]          res_q;
	logic                   flag_q;
	logic                   out_valid_q;
	logic [VW-1:0]          out_inv_q;
	logic                   out_flag_q;

	logic [MW:0]            rem_shift;
	logic                   ge;
	logic [MW:0]            rem_sub;
	logic signed [TW-1:0]   acc_next;
	logic signed [TW-1:0]   t0_fix;
	logic                   out_free;

	minv_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign cfg_ready      = 1'b1;
	assign in_stall       = (ctrl.wt != WT_IN);
	assign out_valid      = out_valid_q;
	assign inverse_value  = out_inv_q;
	assign not_invertible = out_flag_q;
	assign out_free       = !out_valid_q || !out_stall;

	always_comb begin
		m_eff     = (modulus_q[MW-1]) ? MOD_MAX : modulus_q;
		rem_shift = {rem_q, r0_q[cnt_q]};
		ge        = (rem_shift >= {1'b0, r1_q});
		rem_sub   = ge ? (rem_shift - {1'b0, r1_q}) : rem_shift;
		acc_next  = (acc_q <<< 1) + (ge ? t1_q : '0);
		t0_fix    = t0_q[TW-1] ? (t0_q + signed'({{(TW-MW){1'b0}}, m_eff})) : t0_q;
		stat.in_valid    = in_valid;
		stat.out_free    = out_free;
		stat.cnt_nz      = (cnt_q != '0);
		stat.r1_zero     = (r1_q == '0);
		stat.m_small     = (modulus_q[MW-1:1] == '0);
		stat.gcd_not_one = (r0_q != MW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= MOD_MAX;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				modulus_q <= cfg_data;
			end
			if (ctrl.op == OP_OUTPUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (in_valid) begin
					r0_q <= {1'b0, value};
					r1_q <= m_eff;
				end
			end
			OP_DIV_START: begin
				rem_q <= '0;
				acc_q <= '0;
				cnt_q <= CW'(MW - 1);
			end
			OP_DIV_STEP: begin
				rem_q <= rem_sub[MW-1:0];
				acc_q <= acc_next;
				cnt_q <= cnt_q - CW'(1);
			end
			OP_SETUP: begin
				r0_q <= m_eff;
				r1_q <= rem_q;
				t0_q <= '0;
				t1_q <= TW'(1);
			end
			OP_UPDATE: begin
				r0_q <= r1_q;
				r1_q <= rem_q;
				t0_q <= t1_q;
				t1_q <= t0_q - acc_q;
			end
			OP_RES_OK: begin
				res_q  <= t0_fix[VW-1:0];
				flag_q <= 1'b0;
			end
			OP_RES_FAIL: begin
				res_q  <= '0;
				flag_q <= 1'b1;
			end
			OP_OUTPUT: begin
				if (out_free) begin
					out_inv_q  <= res_q;
					out_flag_q <= flag_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_invertible |-> inverse_value == '0)
		else $error("failed inverse carries a nonzero value");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_UPDATE |-> rem_q < r1_q)
		else $error("divider remainder not below the divisor");

	a_gcd_one: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_RES_OK |-> r0_q == MW'(1))
		else $error("inverse produced with gcd other than one");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat taken while an item is in work");

endmodule
